// File: rtl/pie_pkg.sv
`timescale 1ns / 1ps

package pie_pkg;

  // Field widths
  localparam int PIX_W = 8;
  localparam int ROW_W = 13;
  localparam int CFG_ADDR_W = 2;

  // Saturation limits for the pixel counter and the row counter
  localparam logic [ROW_W-1:0] CNT_CAP = ROW_W'(4096);
  localparam logic [ROW_W-1:0] ROW_CAP = ROW_W'(4096);

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_COUNT_THRESHOLD = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_MIN_RUN_LENGTH  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_MERGE_GAP       = 2'd2;

  // Configuration reset values
  localparam logic [ROW_W-1:0] RST_COUNT_THRESHOLD = ROW_W'(1);
  localparam logic [ROW_W-1:0] RST_MIN_RUN_LENGTH  = ROW_W'(3);
  localparam logic [ROW_W-1:0] RST_MERGE_GAP       = ROW_W'(2);

  // One registered pixel on its way into the tracker
  typedef struct packed {
    logic             valid;
    logic [PIX_W-1:0] pixel_value;
    logic             line_end;
    logic             frame_end;
  } pixel_t;

  // One range result from the tracker
  typedef struct packed {
    logic             valid;
    logic [ROW_W-1:0] range_low;
    logic [ROW_W-1:0] range_high;
    logic             frame_done;
  } result_t;

endpackage

// File: rtl/projection_interval_extractor_unit.sv
`timescale 1ns / 1ps
// Path: a pixel is registered in the input register, and the range that it causes
//   is registered in the result register.
// Throughput: one pixel per cycle unless output stalls; row and run state update per pixel.
// Reset: rst_n synchronous, active low; clears pipeline and frame state and loads
//   count_threshold = 1, min_run_length = 3, merge_gap = 2.

module projection_interval_extractor_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  // Configuration write port
  input  logic                           cfg_wr_en,
  input  logic [pie_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [pie_pkg::ROW_W-1:0]      cfg_wdata,
  // Pixel stream
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // [7:0] pixel_value
  input  logic                           in_tlast,   // line_end
  input  logic                           in_tuser,   // frame_end
  // Range stream
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [31:0]                    out_tdata,  // [12:0] range_low, [25:13] range_high
  output logic                           out_tlast   // frame_done
);
  import pie_pkg::*;

  pixel_t           pix;
  result_t          res;
  logic             adv;
  logic [ROW_W-1:0] range_low;
  logic [ROW_W-1:0] range_high;

  pie_in_stage u_in_stage (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_pixel_value (in_tdata[PIX_W-1:0]),
    .in_line_end    (in_tlast),
    .in_frame_end   (in_tuser),
    .adv            (adv),
    .pix            (pix)
  );

  pie_run_tracker u_run_tracker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .pix       (pix),
    .adv       (adv),
    .res       (res)
  );

  pie_out_stage u_out_stage (
    .clk            (clk),
    .rst_n          (rst_n),
    .res            (res),
    .adv            (adv),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_range_low  (range_low),
    .out_range_high (range_high),
    .out_frame_done (out_tlast)
  );

  assign out_tdata = {6'd0, range_high, range_low};

endmodule

// File: rtl/pie_in_stage.sv
`timescale 1ns / 1ps

module pie_in_stage (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [pie_pkg::PIX_W-1:0] in_pixel_value,
  input  logic                      in_line_end,
  input  logic                      in_frame_end,
  input  logic                      adv,
  output pie_pkg::pixel_t           pix
);
  import pie_pkg::*;

  logic             valid_r;
  logic [PIX_W-1:0] pixel_value_r;
  logic             line_end_r;
  logic             frame_end_r;
  logic             accept;

  // Register frees up when its pixel moves on this cycle
  assign in_tready = !valid_r || adv;
  assign accept    = in_tvalid && in_tready;

  // Valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (accept) begin
      pixel_value_r <= in_pixel_value;
      line_end_r    <= in_line_end;
      frame_end_r   <= in_frame_end;
    end
  end

  assign pix.valid       = valid_r;
  assign pix.pixel_value = pixel_value_r;
  assign pix.line_end    = line_end_r;
  assign pix.frame_end   = frame_end_r;

endmodule

// File: rtl/pie_run_tracker.sv
`timescale 1ns / 1ps

module pie_run_tracker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [pie_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [pie_pkg::ROW_W-1:0]      cfg_wdata,
  input  pie_pkg::pixel_t                pix,
  input  logic                           adv,
  output pie_pkg::result_t               res
);
  import pie_pkg::*;

  // Configuration
  logic [ROW_W-1:0] count_threshold_r;
  logic [ROW_W-1:0] min_run_length_r;
  logic [ROW_W-1:0] merge_gap_r;

  // Frame state
  logic [ROW_W-1:0] row_pixel_count_r, row_pixel_count_nxt;
  logic [ROW_W-1:0] row_index_r,       row_index_nxt;
  logic [ROW_W-1:0] run_start_row_r,   run_start_row_nxt;
  logic             run_active_r,      run_active_nxt;
  logic [ROW_W-1:0] last_end_row_r,    last_end_row_nxt;
  logic             last_end_valid_r,  last_end_valid_nxt;
  logic [ROW_W-1:0] pending_low_r,     pending_low_nxt;
  logic [ROW_W-1:0] pending_high_r,    pending_high_nxt;
  logic             pending_valid_r,   pending_valid_nxt;
  logic             any_emitted_r,     any_emitted_nxt;

  logic             fire;
  logic [ROW_W-1:0] cnt_inc;
  logic             qualify;
  logic             emit;
  logic [ROW_W-1:0] emit_low;
  logic [ROW_W-1:0] emit_high;

  assign fire = pix.valid && adv;

  // Configuration writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_threshold_r <= RST_COUNT_THRESHOLD;
      min_run_length_r  <= RST_MIN_RUN_LENGTH;
      merge_gap_r       <= RST_MERGE_GAP;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        CFG_COUNT_THRESHOLD: count_threshold_r <= cfg_wdata;
        CFG_MIN_RUN_LENGTH:  min_run_length_r  <= cfg_wdata;
        CFG_MERGE_GAP:       merge_gap_r       <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Row evaluation and frame flush for one pixel
  always_comb begin
    row_pixel_count_nxt = row_pixel_count_r;
    row_index_nxt       = row_index_r;
    run_start_row_nxt   = run_start_row_r;
    run_active_nxt      = run_active_r;
    last_end_row_nxt    = last_end_row_r;
    last_end_valid_nxt  = last_end_valid_r;
    pending_low_nxt     = pending_low_r;
    pending_high_nxt    = pending_high_r;
    pending_valid_nxt   = pending_valid_r;
    any_emitted_nxt     = any_emitted_r;
    emit                = 1'b0;
    emit_low            = '0;
    emit_high           = '0;

    cnt_inc = (pix.pixel_value != '0 && row_pixel_count_r < CNT_CAP)
            ? row_pixel_count_r + ROW_W'(1) : row_pixel_count_r;
    qualify = cnt_inc >= count_threshold_r;
    row_pixel_count_nxt = cnt_inc;

    if (pix.line_end || pix.frame_end) begin
      row_pixel_count_nxt = '0;
      if (row_index_r < ROW_CAP) begin
        if (qualify && !run_active_r) begin
          if (last_end_valid_r && pending_valid_r &&
              (row_index_r - last_end_row_r) < merge_gap_r) begin
            // Run opens close behind the last end: stretch the pending range
            pending_high_nxt = row_index_r + ROW_W'(1);
            last_end_row_nxt = row_index_r;
          end else begin
            if (pending_valid_r) begin
              emit              = 1'b1;
              emit_low          = pending_low_r;
              emit_high         = pending_high_r;
              pending_valid_nxt = 1'b0;
              any_emitted_nxt   = 1'b1;
            end
            run_active_nxt    = 1'b1;
            run_start_row_nxt = row_index_r;
          end
        end else if (!qualify && run_active_r) begin
          if ((row_index_r - run_start_row_r) >= min_run_length_r) begin
            pending_low_nxt    = run_start_row_r;
            pending_high_nxt   = row_index_r;
            pending_valid_nxt  = 1'b1;
            last_end_row_nxt   = row_index_r;
            last_end_valid_nxt = 1'b1;
          end
          run_active_nxt = 1'b0;
        end
        row_index_nxt = row_index_r + ROW_W'(1);
      end
    end

    if (pix.frame_end) begin
      // Flush the pending range, or report the whole frame if nothing came out
      if (!emit) begin
        if (pending_valid_nxt) begin
          emit      = 1'b1;
          emit_low  = pending_low_nxt;
          emit_high = pending_high_nxt;
        end else if (!any_emitted_nxt) begin
          emit      = 1'b1;
          emit_low  = '0;
          emit_high = row_index_nxt;
        end
      end
      row_pixel_count_nxt = '0;
      row_index_nxt       = '0;
      run_start_row_nxt   = '0;
      run_active_nxt      = 1'b0;
      last_end_row_nxt    = '0;
      last_end_valid_nxt  = 1'b0;
      pending_low_nxt     = '0;
      pending_high_nxt    = '0;
      pending_valid_nxt   = 1'b0;
      any_emitted_nxt     = 1'b0;
    end
  end

  // State update on each processed pixel
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_pixel_count_r <= '0;
      row_index_r       <= '0;
      run_start_row_r   <= '0;
      run_active_r      <= 1'b0;
      last_end_row_r    <= '0;
      last_end_valid_r  <= 1'b0;
      pending_low_r     <= '0;
      pending_high_r    <= '0;
      pending_valid_r   <= 1'b0;
      any_emitted_r     <= 1'b0;
    end else if (fire) begin
      row_pixel_count_r <= row_pixel_count_nxt;
      row_index_r       <= row_index_nxt;
      run_start_row_r   <= run_start_row_nxt;
      run_active_r      <= run_active_nxt;
      last_end_row_r    <= last_end_row_nxt;
      last_end_valid_r  <= last_end_valid_nxt;
      pending_low_r     <= pending_low_nxt;
      pending_high_r    <= pending_high_nxt;
      pending_valid_r   <= pending_valid_nxt;
      any_emitted_r     <= any_emitted_nxt;
    end
  end

  assign res.valid      = fire && emit;
  assign res.range_low  = emit_low;
  assign res.range_high = emit_high;
  assign res.frame_done = pix.frame_end;

endmodule

// File: rtl/pie_out_stage.sv
`timescale 1ns / 1ps

module pie_out_stage (
  input  logic                      clk,
  input  logic                      rst_n,
  input  pie_pkg::result_t          res,
  output logic                      adv,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [pie_pkg::ROW_W-1:0] out_range_low,
  output logic [pie_pkg::ROW_W-1:0] out_range_high,
  output logic                      out_frame_done
);
  import pie_pkg::*;

  logic             valid_r;
  logic [ROW_W-1:0] range_low_r;
  logic [ROW_W-1:0] range_high_r;
  logic             frame_done_r;

  // Upstream may proceed whenever this slot is empty or drains now
  assign adv = !valid_r || out_tready;

  // Valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= res.valid;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (adv && res.valid) begin
      range_low_r  <= res.range_low;
      range_high_r <= res.range_high;
      frame_done_r <= res.frame_done;
    end
  end

  assign out_tvalid     = valid_r;
  assign out_range_low  = range_low_r;
  assign out_range_high = range_high_r;
  assign out_frame_done = frame_done_r;

endmodule

// File: rtl/pie_checker.sv
`timescale 1ns / 1ps

module pie_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tlast
);
  import pie_pkg::*;

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast))
    else $error("result payload changed while stalled");

  // Ranges are ordered and within the row limit; padding bits are zero
  a_range_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[12:0] <= out_tdata[25:13]) &&
                   (out_tdata[25:13] <= ROW_CAP) && (out_tdata[31:26] == 6'd0))
    else $error("malformed range");

  // With the result slot empty the pixel input never stalls
  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty result slot");

endmodule

bind projection_interval_extractor_unit pie_checker u_pie_checker (.*);
